// ===== rtl/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and helper functions for the UTF-8 to UTF-16
// transcoder: the job record passed from the front end to the back end.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Widths of the payload and of one decoded code point
  localparam int BYTE_W  = 8;
  localparam int UNIT_W  = 16;
  localparam int POINT_W = 21;

  // Most code points one input byte can release (early end of a 4-byte lead)
  localparam int MAX_POINTS = 3;
  localparam int NPTS_W     = 2;
  localparam int IDX_W      = $clog2(MAX_POINTS);

  // Default depth of the job queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  // Sequence lengths announced by a lead byte
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_1    = 3'd1;
  localparam logic [2:0] SEQ_2    = 3'd2;
  localparam logic [2:0] SEQ_3    = 3'd3;
  localparam logic [2:0] SEQ_4    = 3'd4;

  // Code point and code unit constants
  localparam logic [POINT_W-1:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [POINT_W-1:0] SUPP_BASE   = 21'h010000;
  localparam logic [UNIT_W-1:0]  HI_SURR     = 16'hD800;
  localparam logic [UNIT_W-1:0]  LO_SURR     = 16'hDC00;

  // One decoded step: up to three code points, in order
  typedef struct packed {
    logic [MAX_POINTS-1:0][POINT_W-1:0] points;
    logic [NPTS_W-1:0]                  n_points;
    logic                               eos;
  } job_t;

  // Sequence length announced by a lead byte; SEQ_NONE for a stray byte
  function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] c);
    logic [2:0] n;
    begin
      if (c[7] == 1'b0) begin
        n = SEQ_1;
      end else if (c[7:5] == 3'b110) begin
        n = SEQ_2;
      end else if (c[7:4] == 4'b1110) begin
        n = SEQ_3;
      end else if (c[7:3] == 5'b11110) begin
        n = SEQ_4;
      end else begin
        n = SEQ_NONE;
      end
      return n;
    end
  endfunction

  // A lone byte decoded as a complete string: ASCII passes, all else replaced
  function automatic logic [POINT_W-1:0] lone_point(input logic [BYTE_W-1:0] c);
    logic [POINT_W-1:0] p;
    begin
      if (c[7] == 1'b0) begin
        p = {{(POINT_W-BYTE_W){1'b0}}, c};
      end else begin
        p = REPLACEMENT;
      end
      return p;
    end
  endfunction

endpackage

// ===== rtl/u8u16_if.sv =====
// ----------------------------------------------------------------------------
// u8u16 channel interfaces
// Valid/ready channels for the byte input and the code-unit output.
// ----------------------------------------------------------------------------
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        run_last;
  logic        string_done;

  modport source (output valid, output code_unit, output run_last, output string_done,
                  input ready);
  modport sink   (input valid, input code_unit, input run_last, input string_done,
                  output ready);
endinterface

// ===== rtl/utf8_to_utf16_transcoder_core.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// Lenient UTF-8 to UTF-16 transcoder with a decoupled front and back end.
// ----------------------------------------------------------------------------
// Usage:
//   utf8  : byte channel; in_byte with end_of_string set on the final byte.
//   utf16 : code-unit channel; run_last marks the last unit caused by one
//           byte, string_done the final unit of the string.
//   One byte is taken per cycle while the job queue has room. A byte that
//   completes a character is queued as a job, and its first code unit is
//   then loaded into the output register. Bytes that open a sequence produce
//   nothing. The back end issues one code unit per cycle while the receiver
//   is ready; a byte that yields more units (surrogate pair, or an early end
//   of string) holds it longer, the queue of QueueDepth jobs absorbs that,
//   and input stalls only when it fills. ASCII text runs at one byte and one
//   unit per cycle unless the receiver stalls; then the output register
//   holds its unit, the back end stops, and the input stalls once the queue
//   is full. Reset (synchronous, active high) closes any open sequence,
//   empties the queue and drops output valid. Held bytes are not cleared.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_core
  import u8u16_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  u8u16_byte_if.sink   utf8,
  u8u16_unit_if.source utf16
);

  logic accept;
  logic push;
  logic full;
  logic pop;
  logic empty;
  job_t push_job;
  job_t head;

  assign utf8.ready = !full;
  assign accept     = utf8.valid && !full;

  u8u16_front front (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (utf8.valid),
    .in_byte       (utf8.in_byte),
    .end_of_string (utf8.end_of_string),
    .accept        (accept),
    .push          (push),
    .job           (push_job)
  );

  u8u16_queue #(
    .Depth (QueueDepth)
  ) queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  u8u16_back back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .head        (head),
    .pop         (pop),
    .unit_valid  (utf16.valid),
    .unit_ready  (utf16.ready),
    .code_unit   (utf16.code_unit),
    .run_last    (utf16.run_last),
    .string_done (utf16.string_done)
  );

endmodule

// ===== rtl/u8u16_front.sv =====
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts bytes, gathers multi-byte sequences and classifies each step into
// a job of up to three code points for the back end.
// ----------------------------------------------------------------------------
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              end_of_string,
  input  logic              accept,
  output logic              push,
  output job_t              job
);

  logic [BYTE_W-1:0] held0;
  logic [BYTE_W-1:0] held1;
  logic [BYTE_W-1:0] held2;
  logic [1:0]        count;
  logic [2:0]        seqlen;

  logic [2:0] need;
  logic       hold;
  logic       complete;

  // Classify the incoming byte against the open sequence
  always_comb begin
    need     = (count == 2'd0) ? lead_len(in_byte) : seqlen;
    complete = (({1'b0, count} + 3'd1) == seqlen);
    hold     = 1'b0;
    job      = '0;
    job.eos  = end_of_string;

    if (count == 2'd0) begin
      if (need == SEQ_1) begin
        job.points[0] = {{(POINT_W-BYTE_W){1'b0}}, in_byte};
        job.n_points  = 2'd1;
      end else if (need != SEQ_NONE && !end_of_string) begin
        hold = 1'b1;
      end else begin
        job.points[0] = REPLACEMENT;
        job.n_points  = 2'd1;
      end
    end else if (complete) begin
      // Assemble the code point; the current byte is always the last one
      job.n_points = 2'd1;
      unique case (seqlen)
        SEQ_2:   job.points[0] = {10'd0, held0[4:0], in_byte[5:0]};
        SEQ_3:   job.points[0] = {5'd0, held0[3:0], held1[5:0], in_byte[5:0]};
        SEQ_4:   job.points[0] = {held0[2:0], held1[5:0], held2[5:0], in_byte[5:0]};
        default: job.points[0] = REPLACEMENT;
      endcase
    end else if (end_of_string) begin
      // Early end: replace the lead, then decode the rest on its own
      job.points[0] = REPLACEMENT;
      if (count == 2'd1) begin
        job.points[1] = lone_point(in_byte);
        job.n_points  = 2'd2;
      end else if (lead_len(held1) == SEQ_2) begin
        job.points[1] = {10'd0, held1[4:0], in_byte[5:0]};
        job.n_points  = 2'd2;
      end else begin
        job.points[1] = lone_point(held1);
        job.points[2] = lone_point(in_byte);
        job.n_points  = 2'd3;
      end
    end else begin
      hold = 1'b1;
    end
  end

  assign push = accept && !hold;

  // Hold bytes of an open sequence
  always_ff @(posedge clk) begin
    if (accept && hold) begin
      case (count)
        2'd0:    held0 <= in_byte;
        2'd1:    held1 <= in_byte;
        default: held2 <= in_byte;
      endcase
    end
  end

  // Track the open sequence; close it on any step that releases a job
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      seqlen <= SEQ_NONE;
    end else if (accept && byte_valid) begin
      if (hold) begin
        count <= count + 2'd1;
        if (count == 2'd0) begin
          seqlen <= need;
        end
      end else begin
        count  <= 2'd0;
        seqlen <= SEQ_NONE;
      end
    end
  end

endmodule

// ===== rtl/u8u16_queue.sv =====
// ----------------------------------------------------------------------------
// u8u16_queue
// Short job queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module u8u16_queue
  import u8u16_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  job_t             slots [Depth];
  logic [AddrW-1:0] wr_ptr;
  logic [AddrW-1:0] rd_ptr;
  logic [CntW-1:0]  fill;

  assign full  = (fill == CntW'(Depth));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AddrW'(Depth - 1)) ? '0 : wr_ptr + AddrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AddrW'(Depth - 1)) ? '0 : rd_ptr + AddrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CntW'(1);
      end else if (pop && !push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/u8u16_back.sv =====
// ----------------------------------------------------------------------------
// u8u16_back
// Walks the head job point by point, splits supplementary points into
// surrogate pairs and drives one code unit per transfer from a register.
// ----------------------------------------------------------------------------
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  job_t              head,
  output logic              pop,
  output logic              unit_valid,
  input  logic              unit_ready,
  output logic [UNIT_W-1:0] code_unit,
  output logic              run_last,
  output logic              string_done
);

  logic [IDX_W-1:0] idx;
  logic             half;

  logic [POINT_W-1:0] cur;
  logic [POINT_W-1:0] offs;
  logic               big;
  logic [UNIT_W-1:0]  unit_next;
  logic               point_last;
  logic               job_last;
  logic               adv;

  // Pick the current unit of the head job
  always_comb begin
    cur        = head.points[idx];
    big        = (cur >= SUPP_BASE);
    offs       = cur - SUPP_BASE;
    if (!big) begin
      unit_next = cur[UNIT_W-1:0];
    end else if (half) begin
      unit_next = LO_SURR | {6'd0, offs[9:0]};
    end else begin
      unit_next = HI_SURR + {5'd0, offs[20:10]};
    end
    point_last = !big || half;
    job_last   = point_last && (idx == IDX_W'(head.n_points - 2'd1));
  end

  assign adv = !empty && (!unit_valid || unit_ready);
  assign pop = adv && job_last;

  // Step through points and surrogate halves
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      half <= 1'b0;
    end else if (adv) begin
      if (job_last) begin
        idx  <= '0;
        half <= 1'b0;
      end else if (point_last) begin
        idx  <= idx + IDX_W'(1);
        half <= 1'b0;
      end else begin
        half <= 1'b1;
      end
    end
  end

  // Output register: load on advance, drop valid once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_valid <= 1'b0;
    end else if (adv) begin
      unit_valid <= 1'b1;
    end else if (unit_ready) begin
      unit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      code_unit   <= unit_next;
      run_last    <= job_last;
      string_done <= job_last && head.eos;
    end
  end

endmodule

// ===== rtl/u8u16_checker.sv =====
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks on the transcoder output channel, bound to the top level.
// ----------------------------------------------------------------------------
module u8u16_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] code_unit,
  input logic        run_last,
  input logic        string_done
);

  // Hold a stalled unit until transfer
  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped before transfer");

  a_unit_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(code_unit) && $stable(run_last)
                                && $stable(string_done))
    else $error("stalled output unit changed");

  // The end of a string always closes the run of its byte
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_done |-> run_last)
    else $error("string_done without run_last");

  // Reset drops any pending unit
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind utf8_to_utf16_transcoder_core u8u16_checker chk (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (utf16.valid),
  .out_ready   (utf16.ready),
  .code_unit   (utf16.code_unit),
  .run_last    (utf16.run_last),
  .string_done (utf16.string_done)
);

// ===== sim/utf16_unit_checker.sv =====
// ----------------------------------------------------------------------------
// utf16_unit_checker
// Passive monitor for the UTF-8 to UTF-16 transcoder. It watches every byte
// transfer on the input channel and runs its own lenient decoder on it. It
// queues the code units that the byte should release. Each unit transfer on
// the output channel is compared, field by field, with the oldest one queued.
// ----------------------------------------------------------------------------
module utf16_unit_checker
  import u8u16_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  u8u16_byte_if utf8_mon,
  u8u16_unit_if utf16_mon,
  output int    fail_count,
  output int    units_pending,
  output int    bytes_seen,
  output int    units_seen,
  output int    strings_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              run_last;
    logic              string_done;
  } unit_rec_t;

  // Decoder state: bytes of the open sequence and its announced length
  logic [BYTE_W-1:0] held_seq [3];
  int                held_n   = 0;
  int                open_len = 0;

  // Scratch for one step: the byte run to decode and the units it yields
  logic [BYTE_W-1:0] run_bytes [4];
  unit_rec_t         step_units [MAX_POINTS];
  int                step_n;

  unit_rec_t expected_units [$];

  int fails     = 0;
  int pend      = 0;
  int bytes_n   = 0;
  int units_n   = 0;
  int strings_n = 0;

  assign fail_count    = fails;
  assign units_pending = pend;
  assign bytes_seen    = bytes_n;
  assign units_seen    = units_n;
  assign strings_seen  = strings_n;

  // Sequence length announced by a byte; SEQ_NONE for a stray byte
  function automatic int announced_len(input logic [BYTE_W-1:0] c);
    if (!c[7]) begin
      return int'(SEQ_1);
    end else if (c[7:5] == 3'b110) begin
      return int'(SEQ_2);
    end else if (c[7:4] == 4'b1110) begin
      return int'(SEQ_3);
    end else if (c[7:3] == 5'b11110) begin
      return int'(SEQ_4);
    end
    return int'(SEQ_NONE);
  endfunction

  // Append one unit; anything past the third is dropped
  task automatic add_unit(input logic [UNIT_W-1:0] u);
    if (step_n < MAX_POINTS) begin
      step_units[step_n] = '{code_unit: u, run_last: 1'b0, string_done: 1'b0};
      step_n++;
    end
  endtask

  // Split a supplementary code point into a surrogate pair, no range check
  task automatic add_point(input logic [POINT_W-1:0] cp);
    logic [POINT_W-1:0] offs;
    if (cp >= SUPP_BASE) begin
      offs = cp - SUPP_BASE;
      add_unit(HI_SURR + UNIT_W'(offs >> 10));
      add_unit(LO_SURR + UNIT_W'(offs[9:0]));
    end else begin
      add_unit(cp[UNIT_W-1:0]);
    end
  endtask

  // Decode run_bytes[0..len-1] as a complete string
  task automatic decode_run(input int len);
    int                 i;
    int                 j;
    int                 n;
    logic [BYTE_W-1:0]  c;
    logic [POINT_W-1:0] cp;
    i = 0;
    while (i < len) begin
      c = run_bytes[i];
      n = announced_len(c);
      if (n == int'(SEQ_1)) begin
        cp = POINT_W'(c);
      end else if (n >= int'(SEQ_2) && i + n - 1 < len) begin
        case (n)
          int'(SEQ_2): cp = POINT_W'(c[4:0]);
          int'(SEQ_3): cp = POINT_W'(c[3:0]);
          default:     cp = POINT_W'(c[2:0]);
        endcase
        for (j = 1; j < n; j++) begin
          cp = (cp << 6) | POINT_W'(run_bytes[i + j][5:0]);
        end
      end else begin
        cp = REPLACEMENT;
        n  = 1;
      end
      i += n;
      add_point(cp);
    end
  endtask

  // Advance the decoder by one byte and queue the units it releases
  task automatic predict_transfer(input logic [BYTE_W-1:0] b, input logic last);
    int cnt;
    int total;
    int need;
    int i;
    cnt = held_n;
    for (i = 0; i < cnt; i++) begin
      run_bytes[i] = held_seq[i];
    end
    run_bytes[cnt] = b;
    total = cnt + 1;
    if (cnt == 0) begin
      need = announced_len(b);
      if (need == int'(SEQ_NONE)) need = int'(SEQ_1);
    end else begin
      need = open_len;
    end
    // Hold the byte while the open sequence is short and the string goes on
    if (!last && total < need && cnt < 3) begin
      if (cnt == 0) open_len = need;
      held_seq[cnt] = b;
      held_n = cnt + 1;
    end else begin
      step_n = 0;
      decode_run(total);
      held_n   = 0;
      open_len = 0;
      if (step_n > 0) begin
        step_units[step_n - 1].run_last    = 1'b1;
        step_units[step_n - 1].string_done = last;
      end
      for (i = 0; i < step_n; i++) begin
        expected_units.insert(expected_units.size(), step_units[i]);
      end
    end
  endtask

  // Compare one unit transfer against the oldest expectation
  task automatic check_unit(input logic [UNIT_W-1:0] cu, input logic rl, input logic sd);
    unit_rec_t want;
    units_n++;
    if (sd) strings_n++;
    if (expected_units.size() == 0) begin
      $error("code_unit %h arrived with no expectation waiting", cu);
      fails++;
    end else begin
      want = expected_units.pop_front();
      if (cu !== want.code_unit) begin
        $error("code_unit mismatch: expected %h, actual %h", want.code_unit, cu);
        fails++;
      end
      if (rl !== want.run_last) begin
        $error("run_last mismatch: expected %b, actual %b", want.run_last, rl);
        fails++;
      end
      if (sd !== want.string_done) begin
        $error("string_done mismatch: expected %b, actual %b", want.string_done, sd);
        fails++;
      end
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (utf8_mon.valid && utf8_mon.ready) begin
        bytes_n++;
        predict_transfer(utf8_mon.in_byte, utf8_mon.end_of_string);
      end
      if (utf16_mon.valid && utf16_mon.ready) begin
        check_unit(utf16_mon.code_unit, utf16_mon.run_last, utf16_mon.string_done);
      end
      pend = expected_units.size();
    end
  end

endmodule

// ===== sim/utf8_to_utf16_transcoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core_tb
// Top of the transcoder testbench. Drives a directed set of byte strings,
// then random well-formed, truncated and noisy strings, under four pacing
// phases of sender gaps and receiver stalls. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_PER_PHASE = 36;
  localparam int DRAIN_CYCLES     = 16;
  localparam int N_PHASES         = 4;
  localparam int IDLE_PCT  [N_PHASES] = '{0, 68, 0, 38};
  localparam int STALL_PCT [N_PHASES] = '{0, 0, 68, 38};

  // Directed bytes as {end_of_string, in_byte}
  localparam int N_DIRECTED = 26;
  localparam logic [8:0] DIRECTED_BYTES [N_DIRECTED] = '{
    9'h100,                                 // NUL as a whole string
    9'h07F, 9'h080, 9'h0BF, 9'h0F8, 9'h0FF, // top ASCII, then stray bytes
    9'h0C2, 9'h0A9,                         // two-byte character
    9'h0E2, 9'h082, 9'h0AC,                 // three-byte character
    9'h0F0, 9'h09F, 9'h098, 9'h080,         // surrogate pair
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,         // beyond the Unicode range
    9'h0F0, 9'h0C3, 9'h1A9,                 // early end, tail decodes to a char
    9'h0F0, 9'h041, 9'h142,                 // early end, three units
    9'h1C3                                  // lead byte as the final byte
  };

  logic clk = 1'b0;
  logic rst;
  int   idle_pct;
  int   stall_pct;
  int   cycles     = 0;
  int   bytes_sent = 0;

  int fail_count;
  int units_pending;
  int bytes_seen;
  int units_seen;
  int strings_seen;

  u8u16_byte_if utf8_ch ();
  u8u16_unit_if utf16_ch ();

  utf8_to_utf16_transcoder_core DUT (
    .clk   (clk),
    .rst   (rst),
    .utf8  (utf8_ch),
    .utf16 (utf16_ch)
  );

  utf16_unit_checker unit_check (
    .clk           (clk),
    .rst           (rst),
    .utf8_mon      (utf8_ch),
    .utf16_mon     (utf16_ch),
    .fail_count    (fail_count),
    .units_pending (units_pending),
    .bytes_seen    (bytes_seen),
    .units_seen    (units_seen),
    .strings_seen  (strings_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[utf8_to_utf16_transcoder_core] ERROR");
      $finish;
    end
  end

  // Stall the receiver at random
  initial begin
    utf16_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      utf16_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offer one byte after a random gap; hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      utf8_ch.valid <= 1'b0;
      @(negedge clk);
    end
    utf8_ch.valid         <= 1'b1;
    utf8_ch.in_byte       <= b;
    utf8_ch.end_of_string <= last;
    do @(posedge clk); while (!utf8_ch.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Well-formed string of random characters, continuation bits random
  task automatic send_text(input int n_chars);
    logic [7:0] char_bytes [4];
    int         len;
    int         c;
    int         k;
    for (c = 0; c < n_chars; c++) begin
      len = $urandom_range(1, 4);
      case (len)
        1:       char_bytes[0] = {1'b0, 7'($urandom)};
        2:       char_bytes[0] = {3'b110, 5'($urandom)};
        3:       char_bytes[0] = {4'b1110, 4'($urandom)};
        default: char_bytes[0] = {5'b11110, 3'($urandom)};
      endcase
      for (k = 1; k < len; k++) begin
        char_bytes[k] = {2'b10, 6'($urandom)};
      end
      for (k = 0; k < len; k++) begin
        send_byte(char_bytes[k], (c == n_chars - 1) && (k == len - 1));
      end
    end
  endtask

  // String cut short inside a multi-byte sequence
  task automatic send_truncated();
    int len;
    int k;
    int tail;
    len  = $urandom_range(2, 4);
    tail = $urandom_range(0, len - 2);
    case (len)
      2:       send_byte({3'b110, 5'($urandom)}, tail == 0);
      3:       send_byte({4'b1110, 4'($urandom)}, tail == 0);
      default: send_byte({5'b11110, 3'($urandom)}, tail == 0);
    endcase
    for (k = 1; k <= tail; k++) begin
      // Tail bytes are mostly continuations, sometimes any byte at all
      if ($urandom_range(0, 3) == 0) begin
        send_byte(8'($urandom), k == tail);
      end else begin
        send_byte({2'b10, 6'($urandom)}, k == tail);
      end
    end
  endtask

  initial begin
    int phase;
    int i;
    int start;
    int pick;
    rst                   = 1'b1;
    utf8_ch.valid         = 1'b0;
    utf8_ch.in_byte       = 8'h00;
    utf8_ch.end_of_string = 1'b0;
    idle_pct              = 0;
    stall_pct             = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (phase = 0; phase < N_PHASES; phase++) begin
      idle_pct  = IDLE_PCT[phase];
      stall_pct = STALL_PCT[phase];
      if (phase == 0) begin
        for (i = 0; i < N_DIRECTED; i++) begin
          send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
        end
      end
      // Mostly well-formed text, some truncated strings and raw noise
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_PER_PHASE) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          send_text($urandom_range(1, 5));
        end else if (pick < 8) begin
          send_truncated();
        end else begin
          send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end
      end
    end
    utf8_ch.valid <= 1'b0;

    // Drain the expected units, then let the back end settle
    do @(negedge clk); while (units_pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d bytes in %0d completed strings, %0d code units checked,",
             bytes_seen, strings_seen, units_seen);
    $display("over %0d pacing phases of sender gaps and receiver stalls.", N_PHASES);
    if (fail_count == 0 && units_pending == 0) begin
      $display("[utf8_to_utf16_transcoder_core] OK");
    end else begin
      $display("[utf8_to_utf16_transcoder_core] ERROR");
    end
    $finish;
  end

endmodule
